@@ rtl/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Widths, codes and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W     = 16;
   localparam int TRACK_W  = 9;
   localparam int KEY_W    = TRACK_W + 1;
   localparam int STATUS_W = 2;
   localparam int POLICY_W = 3;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [POLICY_W-1:0] POL_FIFO  = 3'd0;
   localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
   localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd2;
   localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd3;
   localparam logic [POLICY_W-1:0] POL_FLOOK = 3'd4;

   localparam logic MODE_ENQUEUE  = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   typedef enum logic [2:0] {
      OP_ENQ,
      OP_FIFO,
      OP_SSTF,
      OP_LOOK,
      OP_CLOOK,
      OP_FLOOK
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      id;
      logic [TRACK_W-1:0]   track;
      logic                 add;
   } drs_cmd_type;

endpackage

@@ rtl/drs_if.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface drs_req_if import drs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [ID_W-1:0]    request_id;
   logic [TRACK_W-1:0] track;

   modport source (output valid, mode, request_id, track, input ready);
   modport sink   (input valid, mode, request_id, track, output ready);
endinterface

interface drs_rsp_if import drs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     chosen_id;
   logic [TRACK_W-1:0]  chosen_track;
   logic [TRACK_W-1:0]  seek_distance;

   modport source (output valid, status, chosen_id, chosen_track, seek_distance,
                   input ready);
   modport sink   (input valid, status, chosen_id, chosen_track, seek_distance,
                   output ready);
endinterface

@@ rtl/disk_request_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler
// Pending track request queue with FIFO, SSTF, LOOK, C-LOOK and F-LOOK pick.
// ----------------------------------------------------------------------------
// Requests enter on req_chan and are decoded against the policy register into
// commands that wait in a two-entry command queue. The back end runs one
// command at a time: an enqueue or an empty dispatch finishes straight from
// idle, and a dispatch with pending requests scans them one slot per cycle
// through a single key comparator, then removes the chosen one. Each result
// word sits in an output register; the back end starts its next command once
// that word has been taken, while the front end keeps accepting into the
// command queue as long as it has room. Write the policy register only while
// the unit is idle.
module disk_request_scheduler_unit import drs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [POLICY_W-1:0] csr_wr_data,
   drs_req_if.sink             req_chan,
   drs_rsp_if.source           rsp_chan
);

   logic        push_valid;
   logic        push_ready;
   drs_cmd_type push_cmd;
   logic        pop_valid;
   logic        pop_ready;
   drs_cmd_type pop_cmd;

   drs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   drs_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   drs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ rtl/drs_front.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler front end
// Holds the policy register and turns each request word into a command.
// ----------------------------------------------------------------------------
module drs_front import drs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [POLICY_W-1:0] csr_wr_data,
   drs_req_if.sink             req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output drs_cmd_type         push_cmd
);

   logic [POLICY_W-1:0] policy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIFO;
      end else if (csr_wr_en) begin
         policy_ff <= csr_wr_data;
      end
   end

   always_comb begin
      push_cmd.id    = req_chan.request_id;
      push_cmd.track = req_chan.track;
      push_cmd.add   = (policy_ff == POL_FLOOK);
      if (req_chan.mode == MODE_ENQUEUE) begin
         push_cmd.op = OP_ENQ;
      end else begin
         // unknown policy codes fall back to arrival order
         unique case (policy_ff)
            POL_SSTF:  push_cmd.op = OP_SSTF;
            POL_LOOK:  push_cmd.op = OP_LOOK;
            POL_CLOOK: push_cmd.op = OP_CLOOK;
            POL_FLOOK: push_cmd.op = OP_FLOOK;
            default:   push_cmd.op = OP_FIFO;
         endcase
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

@@ rtl/drs_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module drs_cmd_fifo import drs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  drs_cmd_type push_cmd,
   output logic        pop_valid,
   input  logic        pop_ready,
   output drs_cmd_type pop_cmd
);

   drs_cmd_type           entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0] fill_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (fill_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff <= (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + CMDQ_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - CMDQ_CNT_W'(1);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == CMDQ_CNT_W'(CMDQ_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("command queue pointers disagree with fill level");

   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> fill_ff == $past(fill_ff) + CMDQ_CNT_W'(1))
      else $error("command queue lost a push");

endmodule

@@ rtl/drs_back.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler back end
// Holds the packed request slots, scans them for the next request and keeps
// the head position, direction and the response register.
// ----------------------------------------------------------------------------
module drs_back import drs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  drs_cmd_type cmd,
   drs_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [ID_W-1:0]      slot_id_ff    [QUEUE_DEPTH];
   logic [TRACK_W-1:0]   slot_track_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_add_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [TRACK_W-1:0]   head_ff;
   logic                 down_ff;

   op_type               op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [KEY_W-1:0]     best_key_ff;
   logic [ID_W-1:0]      best_id_ff;
   logic [TRACK_W-1:0]   best_track_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [TRACK_W-1:0]   rsp_track_ff;
   logic [TRACK_W-1:0]   rsp_dist_ff;

   logic [TRACK_W-1:0]   rd_track;
   logic [ID_W-1:0]      rd_id;
   logic                 rd_add;
   logic                 ahead;
   logic                 behind;
   logic [TRACK_W-1:0]   rd_dist;
   logic [KEY_W-1:0]     key;
   logic                 take;
   logic                 scan_last;
   logic [QUEUE_DEPTH-1:0] slot_valid;
   logic                 any_active;
   logic                 is_full;
   logic [IDX_W-1:0]     enq_idx;
   logic [TRACK_W-1:0]   best_dist;
   logic                 do_start;

   // one slot per cycle through a single key compare
   always_comb begin
      rd_track = slot_track_ff[idx_ff];
      rd_id    = slot_id_ff[idx_ff];
      rd_add   = slot_add_ff[idx_ff];
      ahead    = (rd_track >= head_ff);
      behind   = (rd_track <= head_ff);
      rd_dist  = ahead ? rd_track - head_ff : head_ff - rd_track;
      case (op_ff) inside
         OP_SSTF:           key = {1'b0, rd_dist};
         OP_LOOK, OP_FLOOK: key = {(down_ff ? !behind : !ahead), rd_dist};
         OP_CLOOK:          key = {!ahead, rd_track};
         default:           key = '0;
      endcase
      take = !(op_ff == OP_FLOOK && rd_add) && (!found_ff || key < best_key_ff);
      scan_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   end

   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         slot_valid[k] = (CNT_W'(k) < count_ff);
      end
      any_active = |(slot_valid & ~slot_add_ff);
      is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
      enq_idx    = count_ff[IDX_W-1:0];
      best_dist  = (best_track_ff >= head_ff) ? best_track_ff - head_ff
                                              : head_ff - best_track_ff;
   end

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign do_start  = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         down_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (do_start) begin
                  rsp_id_ff    <= '0;
                  rsp_track_ff <= '0;
                  rsp_dist_ff  <= '0;
                  if (cmd.op == OP_ENQ) begin
                     rsp_valid_ff <= 1'b1;
                     if (is_full) begin
                        rsp_status_ff <= ST_FULL;
                     end else begin
                        slot_id_ff[enq_idx]    <= cmd.id;
                        slot_track_ff[enq_idx] <= cmd.track;
                        slot_add_ff[enq_idx]   <= cmd.add;
                        count_ff      <= count_ff + CNT_W'(1);
                        rsp_status_ff <= ST_ENQUEUED;
                     end
                  end else if (count_ff == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_EMPTY;
                  end else begin
                     op_ff    <= cmd.op;
                     idx_ff   <= '0;
                     found_ff <= 1'b0;
                     // active queue drained: swap the add queue in
                     if (cmd.op == OP_FLOOK && !any_active) begin
                        slot_add_ff <= '0;
                     end
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (take) begin
                  found_ff      <= 1'b1;
                  best_idx_ff   <= idx_ff;
                  best_key_ff   <= key;
                  best_id_ff    <= rd_id;
                  best_track_ff <= rd_track;
               end
               if (scan_last) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               if (found_ff) begin
                  rsp_status_ff <= ST_DISPATCHED;
                  rsp_id_ff     <= best_id_ff;
                  rsp_track_ff  <= best_track_ff;
                  rsp_dist_ff   <= best_dist;
                  if (op_ff == OP_LOOK || op_ff == OP_FLOOK) begin
                     if (best_track_ff < head_ff) begin
                        down_ff <= 1'b1;
                     end else if (best_track_ff > head_ff) begin
                        down_ff <= 1'b0;
                     end
                  end
                  head_ff  <= best_track_ff;
                  count_ff <= count_ff - CNT_W'(1);
                  // close the gap, keep arrival order
                  for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                     if (IDX_W'(k) >= best_idx_ff) begin
                        slot_id_ff[k]    <= slot_id_ff[k + 1];
                        slot_track_ff[k] <= slot_track_ff[k + 1];
                        slot_add_ff[k]   <= slot_add_ff[k + 1];
                     end
                  end
               end else begin
                  rsp_status_ff <= ST_EMPTY;
                  rsp_id_ff     <= '0;
                  rsp_track_ff  <= '0;
                  rsp_dist_ff   <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.chosen_id     = rsp_id_ff;
   assign rsp_chan.chosen_track  = rsp_track_ff;
   assign rsp_chan.seek_distance = rsp_dist_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("pending count beyond queue depth");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> CNT_W'(idx_ff) < count_ff)
      else $error("scan index past the pending requests");

   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !rsp_valid_ff)
      else $error("command in progress while a response word waits");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_status_ff == ST_DISPATCHED |->
         head_ff == rsp_track_ff && count_ff == $past(count_ff) - CNT_W'(1))
      else $error("dispatch did not move the head or remove the request");

endmodule

@@ dv/drs_schedule_check.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler result check
// Watches the request, response and policy ports, works out the response word
// for every accepted request word from its own copy of the queue, and compares
// each response word in order.
// ----------------------------------------------------------------------------
module drs_schedule_check import drs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [POLICY_W-1:0] csr_wr_data,
   drs_req_if                  req_mon,
   drs_rsp_if                  rsp_mon,
   output int                  fail_count,
   output int                  waiting_words,
   output int                  checked_words
);

   localparam int TRACK_MAX = (1 << TRACK_W) - 1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     id;
      logic [TRACK_W-1:0]  track;
      logic [TRACK_W-1:0]  seek;
   } sched_result_type;

   logic                pend_valid    [QUEUE_DEPTH];
   logic [ID_W-1:0]     pend_id       [QUEUE_DEPTH];
   logic [TRACK_W-1:0]  pend_track    [QUEUE_DEPTH];
   logic                pend_deferred [QUEUE_DEPTH];
   logic [TRACK_W-1:0]  head_track;
   logic                heading_down;
   logic [POLICY_W-1:0] policy_reg;
   sched_result_type    expected_q [$];
   int                  fail_total    = 0;
   int                  checked_total = 0;

   function automatic int head_gap(input logic [TRACK_W-1:0] t);
      int d;
      d = int'(t) - int'(head_track);
      return (d < 0) ? -d : d;
   endfunction

   // Oldest pending slot holding the lowest (or highest) track within [lo, hi].
   function automatic int nearest_slot(input int lo, input int hi, input bit want_max,
                                       input bit only_active);
      int best;
      int t;
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (!pend_valid[i] || (only_active && pend_deferred[i])) continue;
         t = int'(pend_track[i]);
         if (t < lo || t > hi) continue;
         if (best < 0 || (want_max ? t > int'(pend_track[best])
                                   : t < int'(pend_track[best])))
            best = i;
      end
      return best;
   endfunction

   function automatic int sweep_slot(input bit only_active);
      int r;
      if (!heading_down) begin
         r = nearest_slot(int'(head_track), TRACK_MAX, 1'b0, only_active);
         if (r < 0) r = nearest_slot(0, int'(head_track), 1'b1, only_active);
      end else begin
         r = nearest_slot(0, int'(head_track), 1'b1, only_active);
         if (r < 0) r = nearest_slot(int'(head_track), TRACK_MAX, 1'b0, only_active);
      end
      return r;
   endfunction

   function automatic int select_slot();
      int best;
      bit any_active;
      best = -1;
      any_active = 1'b0;
      case (policy_reg)
         POL_SSTF: begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
               if (pend_valid[i] &&
                   (best < 0 || head_gap(pend_track[i]) < head_gap(pend_track[best])))
                  best = i;
         end
         POL_LOOK: best = sweep_slot(1'b0);
         POL_CLOOK: begin
            best = nearest_slot(int'(head_track), TRACK_MAX, 1'b0, 1'b0);
            if (best < 0) best = nearest_slot(0, TRACK_MAX, 1'b0, 1'b0);
         end
         POL_FLOOK: begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
               if (pend_valid[i] && !pend_deferred[i]) any_active = 1'b1;
            // promote the add queue once the active set has run dry
            if (!any_active)
               for (int i = 0; i < QUEUE_DEPTH; i++) pend_deferred[i] = 1'b0;
            best = sweep_slot(1'b1);
         end
         default: begin
            for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
               if (pend_valid[i]) best = i;
         end
      endcase
      return best;
   endfunction

   function automatic sched_result_type schedule_word(input logic mode,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [TRACK_W-1:0] track);
      sched_result_type res;
      int slot;
      logic [TRACK_W-1:0] t;
      res = '0;
      if (mode == MODE_ENQUEUE) begin
         slot = -1;
         for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
            if (!pend_valid[i]) slot = i;
         if (slot < 0) begin
            res.status = ST_FULL;
         end else begin
            pend_valid[slot]    = 1'b1;
            pend_id[slot]       = id;
            pend_track[slot]    = track;
            pend_deferred[slot] = (policy_reg == POL_FLOOK);
            res.status = ST_ENQUEUED;
         end
         return res;
      end
      slot = select_slot();
      if (slot < 0) begin
         res.status = ST_EMPTY;
         return res;
      end
      t = pend_track[slot];
      res.status = ST_DISPATCHED;
      res.id     = pend_id[slot];
      res.track  = t;
      res.seek   = TRACK_W'(head_gap(t));
      if (policy_reg == POL_LOOK || policy_reg == POL_FLOOK) begin
         if (t < head_track) heading_down = 1'b1;
         else if (t > head_track) heading_down = 1'b0;
      end
      head_track = t;
      // close the gap so pending requests stay packed in arrival order
      for (int k = slot; k < QUEUE_DEPTH - 1; k++) begin
         pend_valid[k]    = pend_valid[k + 1];
         pend_id[k]       = pend_id[k + 1];
         pend_track[k]    = pend_track[k + 1];
         pend_deferred[k] = pend_deferred[k + 1];
      end
      pend_valid[QUEUE_DEPTH - 1]    = 1'b0;
      pend_id[QUEUE_DEPTH - 1]       = '0;
      pend_track[QUEUE_DEPTH - 1]    = '0;
      pend_deferred[QUEUE_DEPTH - 1] = 1'b0;
      return res;
   endfunction

   task automatic report_fail(input string what, input sched_result_type want,
                              input sched_result_type got);
      fail_total++;
      if (fail_total <= 10) begin
         $display("%0t %s: expected status %0d id %h track %0d seek %0d",
                  $time, what, want.status, want.id, want.track, want.seek);
         $display("%0t %s: actual   status %0d id %h track %0d seek %0d",
                  $time, what, got.status, got.id, got.track, got.seek);
      end
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      sched_result_type pred;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pend_valid[i]    = 1'b0;
            pend_id[i]       = '0;
            pend_track[i]    = '0;
            pend_deferred[i] = 1'b0;
         end
         head_track   = '0;
         heading_down = 1'b0;
         policy_reg   = POL_FIFO;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.id     = rsp_mon.chosen_id;
            got.track  = rsp_mon.chosen_track;
            got.seek   = rsp_mon.seek_distance;
            if (expected_q.size() == 0) begin
               report_fail("response word with none outstanding", '0, got);
            end else begin
               want = expected_q.pop_front();
               checked_total++;
               if (got.status != want.status || got.id != want.id ||
                   got.track != want.track || got.seek != want.seek)
                  report_fail("response word mismatch", want, got);
            end
         end
         if (csr_wr_en) policy_reg = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            pred = schedule_word(req_mon.mode, req_mon.request_id, req_mon.track);
            expected_q = {expected_q, pred};
         end
      end
      fail_count    <= fail_total;
      waiting_words <= expected_q.size();
      checked_words <= checked_total;
   end

endmodule

@@ dv/tb_disk_request_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Runs a directed pass over every pick policy and the queue corner cases, then
// randomized fill and drain bursts under each policy code with varying idle and
// stall mixes and long response hold-offs; a separate check module predicts
// and compares every response word.
// ----------------------------------------------------------------------------
module tb_disk_request_scheduler_unit;
   import drs_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_COUNT  = 14;
   localparam int PHASE_WORDS  = 57;
   localparam int DRAIN_CYCLES = 40;
   localparam int RUN_LIMIT    = 20 * 400000;

   // policy codes past F-LOOK fall back to FIFO
   localparam logic [POLICY_W-1:0] POL_RSVD_LO  = 3'd5;
   localparam logic [POLICY_W-1:0] POL_RSVD_MID = 3'd6;
   localparam logic [POLICY_W-1:0] POL_RSVD_HI  = 3'd7;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [POLICY_W-1:0] csr_wr_data;

   int fail_count;
   int waiting_words;
   int checked_words;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   int holds_served       = 0;
   int hold_left          = 0;
   int queue_fill         = 0;
   int enq_words          = 0;
   int disp_words         = 0;
   int policy_writes      = 0;

   drs_req_if req_chan ();
   drs_rsp_if rsp_chan ();

   disk_request_scheduler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   drs_schedule_check schedule_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .waiting_words (waiting_words),
      .checked_words (checked_words)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [POLICY_W-1:0] phase_policy(input int ph);
      case (ph)
         0:       return POL_FIFO;
         1:       return POL_SSTF;
         2:       return POL_LOOK;
         3:       return POL_CLOOK;
         4:       return POL_FLOOK;
         5:       return POL_LOOK;
         6:       return POL_FLOOK;
         7:       return POL_SSTF;
         8:       return POL_RSVD_HI;
         9:       return POL_CLOOK;
         10:      return POL_RSVD_LO;
         11:      return POL_FLOOK;
         12:      return POL_RSVD_MID;
         default: return POL_FIFO;
      endcase
   endfunction

   // favor repeated tracks and the disk edges so ties and head hits show up
   function automatic logic [TRACK_W-1:0] random_track();
      int roll;
      roll = $urandom_range(9);
      case (roll) inside
         0:       return '0;
         1:       return '1;
         2, 3:    return TRACK_W'($urandom_range(7) * 73);
         default: return TRACK_W'($urandom);
      endcase
   endfunction

   task automatic offer_word(input logic mode, input logic [ID_W-1:0] id,
                             input logic [TRACK_W-1:0] track);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.request_id <= id;
      req_chan.track      <= track;
      do @(posedge clock); while (!req_chan.ready);
      if (mode == MODE_ENQUEUE) begin
         enq_words++;
         if (queue_fill < QUEUE_DEPTH) queue_fill++;
      end else begin
         disp_words++;
         if (queue_fill > 0) queue_fill--;
      end
   endtask

   task automatic write_policy(input logic [POLICY_W-1:0] p);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (waiting_words != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      policy_writes++;
   endtask

   // steer the queue toward a fill level that changes every couple dozen words
   task automatic random_words(input int count);
      int fill_goal;
      int roll;
      logic mode;
      fill_goal = 4;
      for (int n = 0; n < count; n++) begin
         if (n % 24 == 0) begin
            roll = $urandom_range(9);
            if (roll < 5)      fill_goal = $urandom_range(0, 6);
            else if (roll < 8) fill_goal = $urandom_range(7, 20);
            else               fill_goal = QUEUE_DEPTH + 2;
         end
         roll = $urandom_range(99);
         if (roll < 10)                  mode = 1'($urandom_range(1));
         else if (queue_fill < fill_goal) mode = (roll < 82) ? MODE_ENQUEUE : MODE_DISPATCH;
         else                            mode = (roll < 82) ? MODE_DISPATCH : MODE_ENQUEUE;
         offer_word(mode, ID_W'($urandom), random_track());
      end
   endtask

   // response side: random stalls, plus long hold-offs on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= POL_FIFO;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_ENQUEUE;
      req_chan.request_id <= '0;
      req_chan.track      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // FIFO out of reset: empty dispatch, field extremes, full-stroke seek
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_ENQUEUE,  16'h0000, 9'd0);
      offer_word(MODE_ENQUEUE,  16'hFFFF, 9'd511);
      offer_word(MODE_ENQUEUE,  16'h5555, 9'h155);
      offer_word(MODE_ENQUEUE,  16'hAAAA, 9'h0AA);
      offer_word(MODE_DISPATCH, 16'hFFFF, 9'd511);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);

      // shortest seek with a tie on equal tracks, then drain to empty
      write_policy(POL_SSTF);
      offer_word(MODE_ENQUEUE,  16'h1234, 9'h0AA);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);

      // LOOK sweeps up to the top request, then reverses
      write_policy(POL_LOOK);
      offer_word(MODE_ENQUEUE,  16'h0001, 9'd400);
      offer_word(MODE_ENQUEUE,  16'h0002, 9'd100);
      offer_word(MODE_ENQUEUE,  16'h0003, 9'd511);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);

      // C-LOOK wraps to the lowest track
      write_policy(POL_CLOOK);
      offer_word(MODE_ENQUEUE,  16'h0004, 9'd50);
      offer_word(MODE_ENQUEUE,  16'h0005, 9'd300);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);

      // F-LOOK swaps the add queue in when nothing is active
      write_policy(POL_FLOOK);
      offer_word(MODE_ENQUEUE,  16'h0006, 9'd200);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);
      offer_word(MODE_ENQUEUE,  16'h0007, 9'd10);
      offer_word(MODE_DISPATCH, 16'h0000, 9'd0);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_policy(phase_policy(ph));
         case (ph % 4)
            0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 47; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 47; end
            default: begin sender_idle_pct <= 15; receiver_stall_pct <= 15; end
         endcase
         // back up the response side so the input stalls
         if (ph == 1 || ph == 8) hold_requests <= hold_requests + 1;
         random_words(PHASE_WORDS);
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (waiting_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d enqueue, %0d dispatch) over %0d policy writes,",
               enq_words + disp_words, enq_words, disp_words, policy_writes);
      $display("with idle and stall mixes and two long response hold-offs; %0d words checked.",
               checked_words);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("simulation failed");
      $finish;
   end

endmodule
